// ----- rtl/pcfb_pkg.sv -----
// Shared constants, types and palette threshold table for the frame blend converter.
`timescale 1ns / 1ps
`default_nettype none

package pcfb_pkg;

    // Frame geometry
    localparam int unsigned FRAME_WIDTH  = 240;
    localparam int unsigned FRAME_HEIGHT = 160;
    localparam int unsigned FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int unsigned POS_W        = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

    // Pixel and channel widths
    localparam int unsigned PIX_W  = 15;
    localparam int unsigned ARGB_W = 32;
    localparam int unsigned SUM_W  = 29;   // weighted sum of fourth powers, max 305 * 31^4
    localparam int unsigned NUM_CH = 3;    // 0 red, 1 green, 2 blue

    // Pipeline depth: accept stage through blend stage
    localparam int unsigned LAST_STG = 12;
    localparam int unsigned RD_STG   = LAST_STG - 1;

    // Configuration port
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_EMULATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUR_ENABLE     = 2'd1;

    // Palette curve constants
    localparam int unsigned WIDE_W   = 384;
    localparam int unsigned OUT_GAIN = 32'hFFFF * 255 / 280;
    localparam int unsigned LIN_DEN  = 255 * 923521;
    localparam logic [31:0] S_LIMIT  = 32'h2000_0000;
    localparam logic [31:0] LVL_NONE = 32'hFFFF_FFFF;

    typedef logic [31:0] level_tab_t [256];

    // Control word that travels with a pixel down the pipeline
    typedef struct packed {
        logic             emu;
        logic             blur;
        logic             fresh;
        logic             last;
        logic [POS_W-1:0] pos;
        logic [PIX_W-1:0] pixel;
    } pix_ctl_t;

    // Widen a 5-bit channel to 8 bits by bit replication
    function automatic logic [7:0] widen5(logic [4:0] x);
        return {x, x[4:2]};
    endfunction

    // Per-byte floor average without carries between bytes
    function automatic logic [ARGB_W-1:0] avg_bytes(logic [ARGB_W-1:0] a,
                                                    logic [ARGB_W-1:0] b);
        return (a & b) + (((a ^ b) & 32'hFEFE_FEFE) >> 1);
    endfunction

    // True when G^11 * s^5 >= (256k)^11 * D^5
    function automatic logic reaches(logic [31:0] s, logic [7:0] k,
                                     logic [WIDE_W-1:0] g11, logic [WIDE_W-1:0] d5);
        logic [WIDE_W-1:0] l;
        logic [WIDE_W-1:0] r;
        l = g11;
        r = d5;
        for (int i = 0; i < 5; i++)
        begin
            l = l * WIDE_W'(s);
        end
        for (int i = 0; i < 11; i++)
        begin
            r = r * (WIDE_W'(k) << 8);
        end
        return (l >= r);
    endfunction

    // Smallest weighted sum that reaches each output level
    function automatic level_tab_t build_level_min();
        level_tab_t        lm;
        logic [WIDE_W-1:0] g11;
        logic [WIDE_W-1:0] d5;
        logic [31:0]       lo;
        logic [31:0]       hi;
        logic [31:0]       mid;
        g11 = WIDE_W'(1);
        d5  = WIDE_W'(1);
        for (int i = 0; i < 11; i++)
        begin
            g11 = g11 * WIDE_W'(OUT_GAIN);
        end
        for (int i = 0; i < 5; i++)
        begin
            d5 = d5 * WIDE_W'(LIN_DEN);
        end
        lm[0] = '0;
        for (int k = 1; k < 256; k++)
        begin
            if (lm[k-1] == LVL_NONE || !reaches(S_LIMIT, 8'(k), g11, d5))
            begin
                lm[k] = LVL_NONE;
            end
            else
            begin
                lo = lm[k-1];
                hi = S_LIMIT;
                while (lo < hi)
                begin
                    mid = lo + ((hi - lo) >> 1);
                    if (reaches(mid, 8'(k), g11, d5))
                    begin
                        hi = mid;
                    end
                    else
                    begin
                        lo = mid + 32'd1;
                    end
                end
                lm[k] = lo;
            end
        end
        return lm;
    endfunction

    localparam level_tab_t LEVEL_MIN = build_level_min();

endpackage

`default_nettype wire

// ----- rtl/palette_convert_frame_blend.sv -----
// Top level: BGR555 to ARGB8888 converter with palette curve and previous-frame blend.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel: in_valid / in_stall with pixel_bgr555, one word per pixel in
//   raster order. Output channel: out_valid / out_stall with pixel_argb and
//   end_of_frame, which marks the last pixel of each frame.
//   Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
//   selects the emulation palette, index 1 enables blending. cfg_ready is always
//   high. Write only while no pixels are in flight.
//   Throughput: one pixel per clock while the output is not stalled. The
//   depth from acceptance to the output comes from the palette path: two
//   squaring stages, a weighted sum and an eight-step threshold search, then
//   the registered frame store read ahead of the blend stage.
//   The frame store is a single-port-per-side RAM, read one stage ahead and
//   written at the blend stage; a back-to-back hit on one entry is forwarded.
//   Reset: modes clear to plain replication without blend, the pixel position
//   returns to zero, and the first frame blends against zeros (the store is not
//   swept; pixels of the first frame ignore its contents).
//   When the receiver stalls with a word held, the whole pipeline freezes and
//   in_stall rises in the same cycle.
module palette_convert_frame_blend
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [pcfb_pkg::PIX_W-1:0]        pixel_bgr555,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [pcfb_pkg::ARGB_W-1:0]            pixel_argb,
    output logic                                   end_of_frame,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pcfb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic                              cfg_data
);
    import pcfb_pkg::*;

    // Configuration and position state
    logic             emu_reg;
    logic             blur_reg;
    logic [POS_W-1:0] pos_reg;
    logic             wrapped_reg;
    logic             pos_last;

    // Pipeline control
    logic                  adv;
    logic                  accept;
    logic [LAST_STG:0]     vld_reg;
    pix_ctl_t              ctl_reg [0:LAST_STG];

    // Palette datapath
    logic [9:0]            sq_reg     [NUM_CH];
    logic [19:0]           quad_reg   [NUM_CH];
    logic [SUM_W-1:0]      srch_s_reg [0:7][NUM_CH];
    logic [7:0]            srch_k_reg [0:8][NUM_CH];
    logic [ARGB_W-1:0]     colour_reg;

    // Frame store and blend
    logic [ARGB_W-1:0]     frame_mem [FRAME_PIXELS];
    logic [ARGB_W-1:0]     mem_q_reg;
    logic                  fwd_hit_reg;
    logic [ARGB_W-1:0]     fwd_data_reg;
    logic [ARGB_W-1:0]     prev_pix;
    logic [ARGB_W-1:0]     blend_pix;

    // Output register
    logic                  out_valid_reg;
    logic [ARGB_W-1:0]     out_pix_reg;
    logic                  out_last_reg;

    // Advance whenever the output register is free or being taken
    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign accept    = in_valid && adv;
    assign cfg_ready = 1'b1;
    assign pos_last  = (pos_reg == POS_W'(FRAME_PIXELS - 1));

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emu_reg  <= 1'b0;
            blur_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COLOR_EMULATION: emu_reg  <= cfg_data;
                CFG_BLUR_ENABLE:     blur_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Advance pixel position and note the first frame wrap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg <= pos_last ? '0 : pos_reg + 1'b1;
            if (pos_last)
            begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    // Shift valid bits and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[LAST_STG-1:0], in_valid};
            out_valid_reg <= vld_reg[LAST_STG];
        end
    end

    // Move control words and palette datapath one stage
    always_ff @(posedge clk)
    begin
        logic [7:0] cand;
        if (adv)
        begin
            ctl_reg[0].emu   <= emu_reg;
            ctl_reg[0].blur  <= blur_reg;
            ctl_reg[0].fresh <= !wrapped_reg;
            ctl_reg[0].last  <= pos_last;
            ctl_reg[0].pos   <= pos_reg;
            ctl_reg[0].pixel <= pixel_bgr555;
            for (int i = 1; i <= LAST_STG; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end

            // Square, then square again for the fourth power
            for (int c = 0; c < NUM_CH; c++)
            begin
                sq_reg[c]   <= 10'(ctl_reg[0].pixel[5*c +: 5]) * 10'(ctl_reg[0].pixel[5*c +: 5]);
                quad_reg[c] <= 20'(sq_reg[c]) * 20'(sq_reg[c]);
            end

            // Weighted sums per output channel
            srch_s_reg[0][0] <= SUM_W'(50) * SUM_W'(quad_reg[1])
                              + SUM_W'(255) * SUM_W'(quad_reg[0]);
            srch_s_reg[0][1] <= SUM_W'(30) * SUM_W'(quad_reg[2])
                              + SUM_W'(230) * SUM_W'(quad_reg[1])
                              + SUM_W'(10) * SUM_W'(quad_reg[0]);
            srch_s_reg[0][2] <= SUM_W'(220) * SUM_W'(quad_reg[2])
                              + SUM_W'(10) * SUM_W'(quad_reg[1])
                              + SUM_W'(50) * SUM_W'(quad_reg[0]);

            // Threshold search, one bit of the level per stage
            for (int c = 0; c < NUM_CH; c++)
            begin
                srch_k_reg[0][c] <= '0;
                for (int j = 1; j <= 8; j++)
                begin
                    cand = srch_k_reg[j-1][c] | (8'd128 >> (j - 1));
                    if (LEVEL_MIN[cand] <= {{(32-SUM_W){1'b0}}, srch_s_reg[j-1][c]})
                    begin
                        srch_k_reg[j][c] <= cand;
                    end
                    else
                    begin
                        srch_k_reg[j][c] <= srch_k_reg[j-1][c];
                    end
                end
                for (int j = 1; j <= 7; j++)
                begin
                    srch_s_reg[j][c] <= srch_s_reg[j-1][c];
                end
            end

            // Pick palette or replicated colour
            if (ctl_reg[RD_STG].emu)
            begin
                colour_reg <= {8'hFF, srch_k_reg[8][0], srch_k_reg[8][1], srch_k_reg[8][2]};
            end
            else
            begin
                colour_reg <= {8'hFF,
                               widen5(ctl_reg[RD_STG].pixel[4:0]),
                               widen5(ctl_reg[RD_STG].pixel[9:5]),
                               widen5(ctl_reg[RD_STG].pixel[14:10])};
            end
        end
    end

    // Select previous-frame pixel: zero in the first frame, else forwarded or stored
    always_comb
    begin
        priority if (ctl_reg[LAST_STG].fresh)
        begin
            prev_pix = '0;
        end
        else if (fwd_hit_reg)
        begin
            prev_pix = fwd_data_reg;
        end
        else
        begin
            prev_pix = mem_q_reg;
        end
        blend_pix = ctl_reg[LAST_STG].blur ? avg_bytes(colour_reg, prev_pix) : colour_reg;
    end

    // Read ahead, write back the blended word, and drive the output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mem_q_reg    <= frame_mem[ctl_reg[RD_STG].pos];
            fwd_hit_reg  <= vld_reg[LAST_STG] && vld_reg[RD_STG]
                         && (ctl_reg[RD_STG].pos == ctl_reg[LAST_STG].pos);
            fwd_data_reg <= blend_pix;
            if (vld_reg[LAST_STG])
            begin
                frame_mem[ctl_reg[LAST_STG].pos] <= blend_pix;
            end
            out_pix_reg  <= blend_pix;
            out_last_reg <= ctl_reg[LAST_STG].last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_argb   = out_pix_reg;
    assign end_of_frame = out_last_reg;

endmodule

`default_nettype wire
